// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the socket demux blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UDSD_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define UDSD_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/udsd_pkg.sv
// ---------------------------------------------------------------------------
// udsd_pkg
// Types, codes and constants of the datagram socket demux table.
// ---------------------------------------------------------------------------
`default_nettype none

package udsd_pkg;

  localparam int ENTRIES       = 64;
  localparam int IDX_W         = $clog2(ENTRIES);
  localparam int CNT_W         = $clog2(ENTRIES + 1);
  localparam int QUEUE_LIMIT   = 16;
  localparam int Q_W           = 5;
  localparam int PORT_ATTEMPTS = 16384;
  localparam int ATT_W         = $clog2(PORT_ATTEMPTS + 1);

  localparam logic [15:0] EPH_BASE    = 16'd49152;
  localparam logic [15:0] PORT_MAX    = 16'hffff;
  localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
  localparam logic [7:0]  LOOP_NET    = 8'd127;
  localparam logic [15:0] LOW_PORTS   = 16'd1024;
  localparam logic [15:0] MAX_PAYLOAD = 16'd1472;
  localparam logic [1:0]  IFACE_BAD   = 2'd3;

  typedef enum logic [2:0] {
    CMD_OPEN    = 3'd0,
    CMD_CLOSE   = 3'd1,
    CMD_OPTIONS = 3'd2,
    CMD_BIND    = 3'd3,
    CMD_CONNECT = 3'd4,
    CMD_DELIVER = 3'd5,
    CMD_DEQUEUE = 3'd6,
    CMD_NOP     = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_FULL     = 4'd1,
    ST_NOT_OPEN = 4'd2,
    ST_BOUND    = 4'd3,
    ST_ADDR     = 4'd4,
    ST_DENIED   = 4'd5,
    ST_IN_USE   = 4'd6,
    ST_DROPPED  = 4'd7,
    ST_EMPTY    = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_OPEN,
    FSM_SLOT,
    FSM_CONF,
    FSM_DLV,
    FSM_EMIT
  } fsm_e;

  typedef struct packed {
    logic              bound;
    logic [31:0]       laddr;
    logic [15:0]       port;
    logic              connected;
    logic [31:0]       paddr;
    logic [15:0]       pport;
    logic [1:0]        iface;
    logic              reuse;
    logic [Q_W-1:0]    queued;
  } entry_t;

  typedef struct packed {
    cmd_e        command;
    logic [5:0]  slot;
    logic [31:0] address;
    logic [15:0] port;
    logic [31:0] source_address;
    logic [15:0] sender_port;
    logic [15:0] length;
    logic [1:0]  interface_req;
    logic        reuse_flag;
    logic        may_bind_low;
    logic        may_bind_device;
    logic        disconnect;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  slot;
    logic [15:0] port;
    logic [4:0]  queued;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } emit_t;

  typedef struct packed {
    logic [IDX_W-1:0] me;
    logic [31:0]      bip;
    logic [15:0]      cand;
    logic             me_reuse;
  } bind_ctx_t;

  typedef struct packed {
    logic hit;
    logic conflict;
  } eval_t;

endpackage

`default_nettype wire

// File: design/udsd_ram.sv
// ---------------------------------------------------------------------------
// udsd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module udsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/udsd_eval.sv
// ---------------------------------------------------------------------------
// udsd_eval
// Judges one table entry: deliver match and bind port conflict.
// ---------------------------------------------------------------------------
`default_nettype none

module udsd_eval
  import udsd_pkg::*;
(
  input  wire entry_t           rec,
  input  wire logic [IDX_W-1:0] rec_idx,
  input  wire cmd_t             cq,
  input  wire bind_ctx_t        bctx,
  output eval_t                 ev
);

  logic iface_ok;
  logic addr_ok;
  logic peer_ok;
  logic room_ok;
  logic addr_apart;

  // An entry that is not open reads as all zero, so it is never bound.
  always_comb begin
    iface_ok   = (rec.iface == 2'd0) || (rec.iface == cq.interface_req);
    addr_ok    = (rec.laddr == 32'd0) || (rec.laddr == cq.address);
    peer_ok    = !rec.connected ||
                 ((rec.paddr == cq.source_address) && (rec.pport == cq.sender_port));
    room_ok    = rec.queued < Q_W'(QUEUE_LIMIT);
    ev.hit     = rec.bound && iface_ok && (rec.port == cq.port) && addr_ok &&
                 peer_ok && room_ok;
    addr_apart = (bctx.bip != 32'd0) && (rec.laddr != 32'd0) && (bctx.bip != rec.laddr);
    ev.conflict = (rec_idx != bctx.me) && rec.bound && (rec.port == bctx.cand) &&
                  !addr_apart && !(bctx.me_reuse && rec.reuse);
  end

endmodule

`default_nettype wire

// File: design/udsd_seq.sv
// ---------------------------------------------------------------------------
// udsd_seq
// Command sequencer: reads, modifies and writes back table entries.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module udsd_seq
  import udsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire cmd_t             cmd_in,
  input  wire logic [31:0]      local_address,
  input  wire logic             out_ready,
  output emit_t                 emit,
  output logic                  mem_we,
  output logic [IDX_W-1:0]      mem_waddr,
  output entry_t                mem_wdata,
  output logic                  mem_re,
  output logic [IDX_W-1:0]      mem_raddr,
  input  wire entry_t           mem_rdata
);

  fsm_e               state, state_next;
  cmd_t               cq, cq_next;
  logic [ENTRIES-1:0] open_q, open_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic               rd_pend, rd_pend_next;
  entry_t             me, me_next;
  logic [15:0]        cand, cand_next;
  logic [ATT_W-1:0]   attempts, attempts_next;
  logic [15:0]        eph, eph_next;
  result_t            pend, pend_next;
  logic               pend_v, pend_v_next;
  result_t            res, res_next;

  entry_t    rec;
  entry_t    nrec;
  bind_ctx_t bctx;
  eval_t     ev;
  logic      accept;
  logic      scan_end;
  logic      hold;
  logic      is_bind;
  logic [15:0] bport;
  logic [15:0] eph_inc;
  logic [ATT_W-1:0] att_inc;

  assign rec      = open_q[rd_idx] ? mem_rdata : '0;
  assign accept   = in_valid && !in_stall;
  assign scan_end = rd_pend && (rd_idx == IDX_W'(ENTRIES - 1));
  assign is_bind  = (cq.command == CMD_BIND);
  assign bport    = is_bind ? cq.port : 16'd0;
  assign eph_inc  = (eph == PORT_MAX) ? EPH_BASE : eph + 16'd1;
  assign att_inc  = attempts + ATT_W'(1);

  always_comb begin
    bctx.me       = cq.slot;
    bctx.bip      = is_bind ? cq.address : 32'd0;
    bctx.cand     = cand;
    bctx.me_reuse = me.reuse;
  end

  udsd_eval u_eval (
    .rec     (rec),
    .rec_idx (rd_idx),
    .cq      (cq),
    .bctx    (bctx),
    .ev      (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FSM_IDLE;
      open_q   <= '0;
      eph      <= EPH_BASE;
      pend_v   <= 1'b0;
      rd_pend  <= 1'b0;
      idx      <= '0;
      attempts <= '0;
    end else begin
      state    <= state_next;
      open_q   <= open_next;
      eph      <= eph_next;
      pend_v   <= pend_v_next;
      rd_pend  <= rd_pend_next;
      idx      <= idx_next;
      attempts <= attempts_next;
    end
  end

  always_ff @(posedge clk) begin
    cq     <= cq_next;
    rd_idx <= rd_idx_next;
    me     <= me_next;
    cand   <= cand_next;
    pend   <= pend_next;
    res    <= res_next;
  end

  always_comb begin
    state_next    = state;
    cq_next       = cq;
    open_next     = open_q;
    idx_next      = idx;
    rd_idx_next   = rd_idx;
    rd_pend_next  = rd_pend;
    me_next       = me;
    cand_next     = cand;
    attempts_next = attempts;
    eph_next      = eph;
    pend_next     = pend;
    pend_v_next   = pend_v;
    res_next      = res;
    in_stall      = (state != FSM_IDLE);
    emit          = '0;
    mem_we        = 1'b0;
    mem_waddr     = rd_idx;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = idx[IDX_W-1:0];
    nrec          = rec;
    hold          = 1'b0;

    case (state)
      FSM_IDLE: begin
        if (accept) begin
          cq_next = cmd_in;
          case (cmd_in.command)
            CMD_NOP: begin
              state_next = FSM_IDLE;
            end
            CMD_OPEN: begin
              idx_next   = '0;
              state_next = FSM_OPEN;
            end
            CMD_DELIVER: begin
              if (cmd_in.length > MAX_PAYLOAD) begin
                res_next   = '{ST_DROPPED, 6'd0, 16'd0, 5'd0, 1'b1};
                state_next = FSM_EMIT;
              end else begin
                idx_next     = '0;
                rd_pend_next = 1'b0;
                pend_v_next  = 1'b0;
                state_next   = FSM_DLV;
              end
            end
            default: begin
              if (!open_q[cmd_in.slot]) begin
                res_next   = '{ST_NOT_OPEN, cmd_in.slot, 16'd0, 5'd0, 1'b1};
                state_next = FSM_EMIT;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = cmd_in.slot;
                rd_idx_next = cmd_in.slot;
                state_next  = FSM_SLOT;
              end
            end
          endcase
        end
      end

      FSM_OPEN: begin
        if (idx == CNT_W'(ENTRIES)) begin
          res_next   = '{ST_FULL, 6'd0, 16'd0, 5'd0, 1'b1};
          state_next = FSM_EMIT;
        end else if (!open_q[idx[IDX_W-1:0]]) begin
          mem_we                     = 1'b1;
          mem_waddr                  = idx[IDX_W-1:0];
          mem_wdata                  = '0;
          open_next[idx[IDX_W-1:0]]  = 1'b1;
          res_next   = '{ST_OK, idx[IDX_W-1:0], 16'd0, 5'd0, 1'b1};
          state_next = FSM_EMIT;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end

      FSM_SLOT: begin
        res_next   = '{ST_OK, cq.slot, rec.port, rec.queued, 1'b1};
        state_next = FSM_EMIT;
        case (cq.command)
          CMD_CLOSE: begin
            open_next[cq.slot] = 1'b0;
            res_next.port      = 16'd0;
            res_next.queued    = 5'd0;
          end
          CMD_OPTIONS: begin
            nrec.reuse = cq.reuse_flag;
            if (cq.interface_req == IFACE_BAD) begin
              res_next.status = ST_ADDR;
            end else if (!cq.may_bind_device) begin
              if (cq.interface_req != rec.iface) begin
                res_next.status = ST_DENIED;
              end
            end else begin
              nrec.iface = cq.interface_req;
            end
            mem_we    = 1'b1;
            mem_wdata = nrec;
          end
          CMD_DEQUEUE: begin
            if (rec.queued == 5'd0) begin
              res_next.status = ST_EMPTY;
            end else begin
              nrec.queued     = rec.queued - 5'd1;
              res_next.queued = nrec.queued;
              mem_we          = 1'b1;
              mem_wdata       = nrec;
            end
          end
          default: begin
            // Bind, and connect: a disconnect, a plain peer update or an implicit bind.
            if (cq.command == CMD_CONNECT && cq.disconnect) begin
              nrec.connected = 1'b0;
              mem_we         = 1'b1;
              mem_wdata      = nrec;
            end else if (cq.command == CMD_CONNECT && rec.bound) begin
              nrec.connected = 1'b1;
              nrec.paddr     = cq.address;
              nrec.pport     = cq.port;
              mem_we         = 1'b1;
              mem_wdata      = nrec;
            end else if (rec.bound) begin
              res_next.status = ST_BOUND;
            end else if (bctx.bip != 32'd0 && bctx.bip[31:24] != LOOP_NET &&
                         bctx.bip != local_address) begin
              res_next.status = ST_ADDR;
            end else if (bport != 16'd0 && bport < LOW_PORTS && !cq.may_bind_low) begin
              res_next.status = ST_DENIED;
            end else begin
              me_next       = rec;
              attempts_next = '0;
              idx_next      = '0;
              rd_pend_next  = 1'b0;
              if (bport != 16'd0) begin
                cand_next = bport;
              end else begin
                cand_next = eph;
                eph_next  = eph_inc;
              end
              state_next = FSM_CONF;
            end
          end
        endcase
      end

      FSM_CONF: begin
        if (rd_pend && ev.conflict) begin
          rd_pend_next = 1'b0;
          idx_next     = '0;
          if (bport != 16'd0 || att_inc == ATT_W'(PORT_ATTEMPTS)) begin
            res_next   = '{ST_IN_USE, cq.slot, me.port, me.queued, 1'b1};
            state_next = FSM_EMIT;
          end else begin
            attempts_next = att_inc;
            cand_next     = eph;
            eph_next      = eph_inc;
          end
        end else if (scan_end) begin
          nrec       = me;
          nrec.bound = 1'b1;
          nrec.laddr = bctx.bip;
          nrec.port  = cand;
          if (cq.command == CMD_CONNECT) begin
            nrec.connected = 1'b1;
            nrec.paddr     = cq.address;
            nrec.pport     = cq.port;
          end
          mem_we     = 1'b1;
          mem_waddr  = cq.slot;
          mem_wdata  = nrec;
          res_next   = '{ST_OK, cq.slot, cand, me.queued, 1'b1};
          state_next = FSM_EMIT;
        end else begin
          mem_re       = (idx != CNT_W'(ENTRIES));
          rd_pend_next = mem_re;
          if (mem_re) begin
            rd_idx_next = idx[IDX_W-1:0];
            idx_next    = idx + CNT_W'(1);
          end
        end
      end

      FSM_DLV: begin
        hold = rd_pend && ev.hit && pend_v && !out_ready;
        if (!hold) begin
          if (rd_pend && ev.hit) begin
            nrec.queued = rec.queued + 5'd1;
            mem_we      = 1'b1;
            mem_waddr   = rd_idx;
            mem_wdata   = nrec;
            if (cq.address != ALL_ONES) begin
              res_next   = '{ST_OK, rd_idx, rec.port, nrec.queued, 1'b1};
              state_next = FSM_EMIT;
            end else begin
              if (pend_v) begin
                emit.valid = 1'b1;
                emit.res   = pend;
              end
              pend_next   = '{ST_OK, rd_idx, rec.port, nrec.queued, 1'b0};
              pend_v_next = 1'b1;
            end
          end
          if (state_next == FSM_DLV) begin
            if (scan_end) begin
              if (pend_v_next) begin
                res_next      = pend_next;
                res_next.last = 1'b1;
              end else begin
                res_next = '{ST_DROPPED, 6'd0, 16'd0, 5'd0, 1'b1};
              end
              state_next = FSM_EMIT;
            end else begin
              mem_re       = (idx != CNT_W'(ENTRIES));
              rd_pend_next = mem_re;
              if (mem_re) begin
                rd_idx_next = idx[IDX_W-1:0];
                idx_next    = idx + CNT_W'(1);
              end
            end
          end
        end
      end

      FSM_EMIT: begin
        if (out_ready) begin
          emit.valid = 1'b1;
          emit.res   = res;
          state_next = FSM_IDLE;
        end
      end

      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  `UDSD_IMPLIES(a_emit_ready, clk, rst, emit.valid, out_ready, "result emitted into a busy output register")
  `UDSD_IMPLIES(a_rw_apart, clk, rst, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same entry in one cycle")
  `UDSD_IMPLIES(a_eph_range, clk, rst, state != FSM_IDLE || !in_stall, eph >= EPH_BASE, "ephemeral counter left its range")
  `UDSD_NEXT(a_hold_keeps, clk, rst, state == FSM_DLV && hold, $stable(rd_idx) && $stable(pend), "deliver scan moved while holding a receiver")

endmodule

`default_nettype wire

// File: design/udp_socket_demux_table_top.sv
// ---------------------------------------------------------------------------
// udp_socket_demux_table_top
// Datagram endpoint table with open, bind, connect and deliver commands.
// ---------------------------------------------------------------------------
// The table of 64 endpoints lives in one synchronous RAM and a command item
// is handled one at a time by a read-modify-write sequencer. Close, set
// options, dequeue and connect on a bound entry issue the entry read in the
// idle state, update the entry in the slot state, hand over the result in
// the emit state once the output register can take it, and take the next
// item in the idle state. Open walks the open flags, one entry per cycle,
// and reports full when none of them is clear. Deliver reads the entries
// in turn through the single RAM read port, up to the first receiver for
// a unicast destination and all of them for the all-ones destination,
// where it gives one result item per receiver and a busy output register
// holds the scan. Bind reads the table once per candidate port and starts
// over on a conflict; a zero port may try up to 16384 ephemeral candidates.
// A result waits in an output register, so the next command item is taken
// while the last result of the previous one is still held there. The open
// flags sit in flip-flops that reset clears, and an entry that is not open
// reads as all zero, so the RAM needs no clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module udp_socket_demux_table_top
  import udsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic [5:0]  slot,
  input  wire logic [31:0] address,
  input  wire logic [15:0] port,
  input  wire logic [31:0] source_address,
  input  wire logic [15:0] sender_port,
  input  wire logic [15:0] length,
  input  wire logic [1:0]  interface_req,
  input  wire logic        reuse_flag,
  input  wire logic        may_bind_low,
  input  wire logic        may_bind_device,
  input  wire logic        disconnect,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       status,
  output logic [5:0]       result_slot,
  output logic [15:0]      bound_port,
  output logic [4:0]       queue_count,
  output logic             last
);

  logic [31:0]      local_address;
  cmd_t             cmd_in;
  emit_t            emit;
  logic             out_ready;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  // Write the host address register only while the table is idle; unchecked.
  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= 32'd0;
    end else if (cfg_we) begin
      local_address <= cfg_data;
    end
  end

  always_comb begin
    cmd_in.command         = cmd_e'(command);
    cmd_in.slot            = slot;
    cmd_in.address         = address;
    cmd_in.port            = port;
    cmd_in.source_address  = source_address;
    cmd_in.sender_port     = sender_port;
    cmd_in.length          = length;
    cmd_in.interface_req   = interface_req;
    cmd_in.reuse_flag      = reuse_flag;
    cmd_in.may_bind_low    = may_bind_low;
    cmd_in.may_bind_device = may_bind_device;
    cmd_in.disconnect      = disconnect;
  end

  // The output register can take a new result when empty or when its
  // current item leaves in this cycle.
  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      status      <= emit.res.status;
      result_slot <= emit.res.slot;
      bound_port  <= emit.res.port;
      queue_count <= emit.res.queued;
      last        <= emit.res.last;
    end
  end

  udsd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  udsd_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd_in        (cmd_in),
    .local_address (local_address),
    .out_ready     (out_ready),
    .emit          (emit),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

endmodule

`default_nettype wire
